/* rtl/core/vm_instruction_execute_core_unit_defines.svh */
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef VM_INSTRUCTION_EXECUTE_CORE_UNIT_DEFINES_SVH
`define VM_INSTRUCTION_EXECUTE_CORE_UNIT_DEFINES_SVH

// same-cycle implication
`define VMX_ASSERT_IMP(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
        else $error("vmx check failed");

// next-cycle implication
`define VMX_ASSERT_NXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
        else $error("vmx check failed");

`endif

/* rtl/core/vmx_pkg.sv */
// Shared types, codes and the font table of the CHIP-8 style core.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none

package vmx_pkg;

    localparam logic [2:0] MODE_EXEC  = 3'd0;
    localparam logic [2:0] MODE_TICK  = 3'd1;
    localparam logic [2:0] MODE_RAMWR = 3'd2;
    localparam logic [2:0] MODE_KEY   = 3'd3;
    localparam logic [2:0] MODE_ROW   = 3'd4;

    localparam logic [2:0] ERR_BADOP = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_UNDER = 3'd3;
    localparam logic [2:0] ERR_RANGE = 3'd4;
    localparam logic [2:0] ERR_LOOP  = 3'd5;

    localparam logic [11:0] ADDR_LAST  = 12'hFFF;
    localparam logic [11:0] PC_RESET   = 12'd512;
    localparam logic [16:0] MEM_LIMIT  = 17'd4096;
    localparam logic [11:0] FONT_BYTES = 12'd80;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;
    localparam logic [7:0] KK_GDT  = 8'h07;
    localparam logic [7:0] KK_WKEY = 8'h0A;
    localparam logic [7:0] KK_SDT  = 8'h15;
    localparam logic [7:0] KK_SST  = 8'h18;
    localparam logic [7:0] KK_ADDI = 8'h1E;
    localparam logic [7:0] KK_FONT = 8'h29;
    localparam logic [7:0] KK_BCD  = 8'h33;
    localparam logic [7:0] KK_STR  = 8'h55;
    localparam logic [7:0] KK_LDR  = 8'h65;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLEAR, DP_LATCH, DP_TICK, DP_RAMWR, DP_KEY, DP_ROWRD, DP_ROWCAP,
        DP_FHI, DP_FLO, DP_RDX, DP_RDY, DP_EXEC, DP_WRVF, DP_JHI, DP_JLO, DP_JCMP,
        DP_LRD, DP_LWR, DP_DEND
    } dp_op_t;

    typedef enum logic [2:0] {
        K_NONE, K_WRVF, K_JUMP, K_DRAW, K_DRAW0, K_BCD, K_STORE, K_LOAD
    } kind_t;

    typedef struct packed {
        dp_op_t      op;
        logic [11:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       stopped;
        logic       pc_last;
        kind_t      kind;
        kind_t      kind_q;
        logic [4:0] cnt;
    } status_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] b;
        case (a)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25, 7'd27,
            7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45, 7'd47,
            7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51, 7'd53,
            7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
            7'd6: b = 8'h60;
            7'd9: b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
            7'd79: b = 8'h80;
            7'd38, 7'd39: b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/vm_instruction_execute_core_unit.sv */
// CHIP-8 style core: one transaction per item, one result per transaction. After reset the
// 4 KB memory is filled with the font and zeros, one byte a cycle; in that time no
// transaction is taken, while writes of the start address on the cfg port are. Memory
// accesses are byte-wide with registered reads, which sets the timing. An executed
// instruction steps through dispatch, fetch, the reads of Vx and Vy and execute, then a VF
// write, or a target read and loop check for a jump or call, or a read and a write per row
// or byte for a draw (then a VF write), Fx33 or Fx55/Fx65. An execute while halted ends after
// fetch, a row read after a capture, other modes after dispatch. The next transaction is
// taken in the cycle after the result is taken. One item is in flight at once.
// Depends on vmx_pkg, vmx_ctrl and vmx_datapath.
`default_nettype none

module vm_instruction_execute_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [11:0] ram_address,
    input  wire logic [7:0]  ram_data,
    input  wire logic [15:0] key_mask,
    input  wire logic [3:0]  key_code,
    input  wire logic [7:0]  random_byte,
    input  wire logic [4:0]  row_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      program_counter,
    output logic             halted,
    output logic [2:0]       error_code,
    output logic             sound_on,
    output logic [63:0]      display_row,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);

    vmx_pkg::cmd_t    cmd;
    vmx_pkg::status_t st;

    assign cfg_ready = 1'b1;

    vmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    vmx_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .ram_address     (ram_address),
        .ram_data        (ram_data),
        .key_mask        (key_mask),
        .key_code        (key_code),
        .random_byte     (random_byte),
        .row_index       (row_index),
        .program_counter (program_counter),
        .halted          (halted),
        .error_code      (error_code),
        .sound_on        (sound_on),
        .display_row     (display_row)
    );

endmodule

`default_nettype wire

/* rtl/core/vmx_ctrl.sv */
// Sequencer of the core: one-hot state machine issuing datapath commands.
// Depends on vmx_pkg for command and status types.
`default_nettype none

module vmx_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire vmx_pkg::status_t st,
    output vmx_pkg::cmd_t         cmd
);

    typedef enum logic [16:0] {
        S_CLR  = 17'b00000000000000001,
        S_IDLE = 17'b00000000000000010,
        S_DISP = 17'b00000000000000100,
        S_RCAP = 17'b00000000000001000,
        S_FHI  = 17'b00000000000010000,
        S_FLO  = 17'b00000000000100000,
        S_RDX  = 17'b00000000001000000,
        S_RDY  = 17'b00000000010000000,
        S_EXEC = 17'b00000000100000000,
        S_VF   = 17'b00000001000000000,
        S_JHI  = 17'b00000010000000000,
        S_JLO  = 17'b00000100000000000,
        S_JCMP = 17'b00001000000000000,
        S_LRD  = 17'b00010000000000000,
        S_LWR  = 17'b00100000000000000,
        S_DEND = 17'b01000000000000000,
        S_DONE = 17'b10000000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [11:0] idx_reg, idx_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign cmd.idx   = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = vmx_pkg::DP_NOP;
        case (state_reg)
            S_CLR:
            begin
                cmd.op   = vmx_pkg::DP_CLEAR;
                idx_next = idx_reg + 12'd1;
                if (idx_reg == vmx_pkg::ADDR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = vmx_pkg::DP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (st.mode)
                    vmx_pkg::MODE_EXEC:  state_next = S_FHI;
                    vmx_pkg::MODE_TICK:  cmd.op = vmx_pkg::DP_TICK;
                    vmx_pkg::MODE_RAMWR: cmd.op = vmx_pkg::DP_RAMWR;
                    vmx_pkg::MODE_KEY:   cmd.op = vmx_pkg::DP_KEY;
                    vmx_pkg::MODE_ROW:
                    begin
                        cmd.op     = vmx_pkg::DP_ROWRD;
                        state_next = S_RCAP;
                    end
                    default: cmd.op = vmx_pkg::DP_NOP;
                endcase
            end
            S_RCAP:
            begin
                cmd.op     = vmx_pkg::DP_ROWCAP;
                state_next = S_DONE;
            end
            S_FHI:
            begin
                cmd.op     = vmx_pkg::DP_FHI;
                state_next = (st.stopped || st.pc_last) ? S_DONE : S_FLO;
            end
            S_FLO:
            begin
                cmd.op     = vmx_pkg::DP_FLO;
                state_next = S_RDX;
            end
            S_RDX:
            begin
                cmd.op     = vmx_pkg::DP_RDX;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                cmd.op     = vmx_pkg::DP_RDY;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.op   = vmx_pkg::DP_EXEC;
                idx_next = '0;
                case (st.kind)
                    vmx_pkg::K_WRVF:  state_next = S_VF;
                    vmx_pkg::K_JUMP:  state_next = S_JHI;
                    vmx_pkg::K_DRAW0: state_next = S_DEND;
                    vmx_pkg::K_DRAW, vmx_pkg::K_BCD, vmx_pkg::K_STORE,
                    vmx_pkg::K_LOAD:  state_next = S_LRD;
                    default:          state_next = S_DONE;
                endcase
            end
            S_VF:
            begin
                cmd.op     = vmx_pkg::DP_WRVF;
                state_next = S_DONE;
            end
            S_JHI:
            begin
                cmd.op     = vmx_pkg::DP_JHI;
                state_next = S_JLO;
            end
            S_JLO:
            begin
                cmd.op     = vmx_pkg::DP_JLO;
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                cmd.op     = vmx_pkg::DP_JCMP;
                state_next = S_DONE;
            end
            S_LRD:
            begin
                cmd.op     = vmx_pkg::DP_LRD;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                cmd.op = vmx_pkg::DP_LWR;
                if (idx_reg[4:0] == st.cnt - 5'd1)
                begin
                    state_next = (st.kind_q == vmx_pkg::K_DRAW) ? S_DEND : S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 12'd1;
                    state_next = S_LRD;
                end
            end
            S_DEND:
            begin
                cmd.op     = vmx_pkg::DP_DEND;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vmx_datapath.sv */
// Datapath of the core: memory, screen, register file, stack and machine state.
// Depends on vmx_pkg; driven step by step by vmx_ctrl commands.
`default_nettype none

module vmx_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vmx_pkg::cmd_t cmd,
    output vmx_pkg::status_t   st,
    input  wire logic          cfg_we,
    input  wire logic [11:0]   cfg_data,
    input  wire logic [2:0]    mode,
    input  wire logic [11:0]   ram_address,
    input  wire logic [7:0]    ram_data,
    input  wire logic [15:0]   key_mask,
    input  wire logic [3:0]    key_code,
    input  wire logic [7:0]    random_byte,
    input  wire logic [4:0]    row_index,
    output logic [11:0]        program_counter,
    output logic               halted,
    output logic [2:0]         error_code,
    output logic               sound_on,
    output logic [63:0]        display_row
);

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    logic [7:0]  mem_array [4096];
    logic [63:0] scr_array [32];
    logic [7:0]  rf_array  [16];
    logic [11:0] stk_array [STACK_DEPTH];
    logic [31:0] scr_vld_reg;
    logic [15:0] rf_vld_reg;

    logic [7:0]  mem_q, rf_q;
    logic [63:0] scr_q;

    logic [11:0] pc_reg, pc_next;
    logic [15:0] ip_reg, ip_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next, sound_reg, sound_next;
    logic [4:0]  pend_reg, pend_next;
    logic        stop_reg, stop_next;
    logic [2:0]  fault_reg, fault_next;
    logic [15:0] ir_reg, ir_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next, jhi_reg, jhi_next;
    logic        flag_reg, flag_next, erase_reg, erase_next;
    logic [4:0]  cnt_reg, cnt_next;
    vmx_pkg::kind_t kind_reg, kind_next, kind_w;
    logic [63:0] row_reg, row_next;
    logic [2:0]  mode_reg, mode_next;
    logic [11:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next, rnd_reg, rnd_next;
    logic [15:0] keys_reg, keys_next;
    logic [3:0]  keyc_reg, keyc_next;
    logic [4:0]  rowi_reg, rowi_next;

    logic        mem_we, rf_we, scr_we, scr_clr, stk_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, rf_wd;
    logic [3:0]  rf_wa, rf_ra;
    logic [4:0]  scr_wa, scr_ra;
    logic [63:0] scr_wd;

    logic [3:0]  x, y, n;
    logic [7:0]  kk;
    logic [11:0] at, op_addr, loop_a;
    logic [PW-1:0] sp_m1;
    logic [8:0]  sum9;
    logic [12:0] jt13;
    logic [16:0] ip17;
    logic [4:0]  li, line_w;
    logic [63:0] pat, cur;
    logic [127:0] pat2;
    logic [1:0]  hund;
    logic [6:0]  rem7, tens7;
    logic [14:0] prod15;
    logic [3:0]  ones4;

    assign x       = ir_reg[11:8];
    assign y       = ir_reg[7:4];
    assign n       = ir_reg[3:0];
    assign kk      = ir_reg[7:0];
    assign op_addr = ir_reg[11:0];
    assign at      = pc_reg;
    assign sp_m1   = sp_reg - 1'b1;
    assign ip17    = {1'b0, ip_reg};
    assign li      = cmd.idx[4:0];
    assign loop_a  = ip_reg[11:0] + {7'b0, li};
    assign line_w  = vy_reg[4:0] + li;
    assign pat2    = {mem_q, 56'b0, mem_q, 56'b0} >> vx_reg[5:0];
    assign pat     = pat2[63:0];
    assign cur     = scr_q;

    assign hund   = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem7   = 7'(vx_reg - 8'd100 * {6'b0, hund});
    assign prod15 = {8'b0, rem7} * 15'd205;
    assign tens7  = {3'b0, prod15[14:11]};
    assign ones4  = 4'(rem7 - tens7 * 7'd10);

    assign st.mode    = mode_reg;
    assign st.stopped = stop_reg;
    assign st.pc_last = (pc_reg == vmx_pkg::ADDR_LAST);
    assign st.kind    = kind_w;
    assign st.kind_q  = kind_reg;
    assign st.cnt     = cnt_reg;

    assign program_counter = pc_reg;
    assign halted          = stop_reg;
    assign error_code      = fault_reg;
    assign sound_on        = (sound_reg != 8'd0);
    assign display_row     = row_reg;

    always_comb
    begin
        pc_next = pc_reg;  ip_next = ip_reg;  sp_next = sp_reg;
        delay_next = delay_reg;  sound_next = sound_reg;  pend_next = pend_reg;
        stop_next = stop_reg;  fault_next = fault_reg;  ir_next = ir_reg;
        vx_next = vx_reg;  vy_next = vy_reg;  jhi_next = jhi_reg;
        flag_next = flag_reg;  erase_next = erase_reg;  cnt_next = cnt_reg;
        kind_next = kind_reg;  row_next = row_reg;  mode_next = mode_reg;
        addr_next = addr_reg;  data_next = data_reg;  rnd_next = rnd_reg;
        keys_next = keys_reg;  keyc_next = keyc_reg;  rowi_next = rowi_reg;
        kind_w = vmx_pkg::K_NONE;
        mem_we = 1'b0;  mem_wa = pc_reg;  mem_wd = 8'd0;  mem_ra = pc_reg;
        rf_we = 1'b0;  rf_wa = x;  rf_wd = 8'd0;  rf_ra = x;
        scr_we = 1'b0;  scr_clr = 1'b0;  scr_wa = line_w;  scr_wd = 64'd0;
        scr_ra = line_w;  stk_we = 1'b0;
        sum9 = 9'd0;  jt13 = 13'd0;
        case (cmd.op)
            vmx_pkg::DP_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cmd.idx;
                mem_wd = (cmd.idx < vmx_pkg::FONT_BYTES) ? vmx_pkg::font_byte(cmd.idx[6:0])
                                                         : 8'd0;
            end
            vmx_pkg::DP_LATCH:
            begin
                mode_next = mode;  addr_next = ram_address;  data_next = ram_data;
                keys_next = key_mask;  keyc_next = key_code;  rnd_next = random_byte;
                rowi_next = row_index;  row_next = 64'd0;
            end
            vmx_pkg::DP_TICK:
            begin
                if (delay_reg != 8'd0) delay_next = delay_reg - 8'd1;
                if (sound_reg != 8'd0) sound_next = sound_reg - 8'd1;
            end
            vmx_pkg::DP_RAMWR:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg;
                mem_wd = data_reg;
            end
            vmx_pkg::DP_KEY:    pend_next = {1'b1, keyc_reg};
            vmx_pkg::DP_ROWRD:  scr_ra = rowi_reg;
            vmx_pkg::DP_ROWCAP: row_next = scr_q;
            vmx_pkg::DP_FHI:
            begin
                if (!stop_reg && pc_reg == vmx_pkg::ADDR_LAST)
                begin
                    stop_next  = 1'b1;
                    fault_next = vmx_pkg::ERR_RANGE;
                end
            end
            vmx_pkg::DP_FLO:
            begin
                ir_next[15:8] = mem_q;
                mem_ra        = pc_reg + 12'd1;
            end
            vmx_pkg::DP_RDX:
            begin
                ir_next[7:0] = mem_q;
                rf_ra        = (ir_reg[15:12] == 4'hB) ? 4'd0 : x;
            end
            vmx_pkg::DP_RDY:
            begin
                vx_next = rf_q;
                rf_ra   = y;
            end
            vmx_pkg::DP_EXEC:
            begin
                vy_next = rf_q;
                pc_next = at + 12'd2;
                case (ir_reg[15:12])
                    4'h0:
                    begin
                        if (ir_reg == vmx_pkg::OP_CLS)
                        begin
                            scr_clr = 1'b1;
                        end
                        else if (ir_reg == vmx_pkg::OP_RET)
                        begin
                            if (sp_reg == '0)
                            begin
                                stop_next = 1'b1;  fault_next = vmx_pkg::ERR_UNDER;
                            end
                            else
                            begin
                                sp_next = sp_m1;
                                pc_next = stk_array[sp_m1[SW-1:0]];
                            end
                        end
                        else
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_BADOP;
                        end
                    end
                    4'h1:
                    begin
                        pc_next = op_addr;
                        if (op_addr != vmx_pkg::ADDR_LAST) kind_w = vmx_pkg::K_JUMP;
                    end
                    4'h2:
                    begin
                        if (sp_reg == PW'(STACK_DEPTH))
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_OVER;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = op_addr;
                            if (op_addr != vmx_pkg::ADDR_LAST) kind_w = vmx_pkg::K_JUMP;
                        end
                    end
                    4'h3: if (vx_reg == kk) pc_next = at + 12'd4;
                    4'h4: if (vx_reg != kk) pc_next = at + 12'd4;
                    4'h5, 4'h9:
                    begin
                        if (n != 4'd0)
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_BADOP;
                        end
                        else if ((vx_reg == rf_q) != ir_reg[15])
                        begin
                            pc_next = at + 12'd4;
                        end
                    end
                    4'h6:
                    begin
                        rf_we = 1'b1;  rf_wd = kk;
                    end
                    4'h7:
                    begin
                        rf_we = 1'b1;  rf_wd = vx_reg + kk;
                    end
                    4'h8:
                    begin
                        rf_we = 1'b1;
                        kind_w = vmx_pkg::K_WRVF;
                        case (n)
                            4'h0: begin rf_wd = rf_q;  kind_w = vmx_pkg::K_NONE; end
                            4'h1: begin rf_wd = vx_reg | rf_q;  kind_w = vmx_pkg::K_NONE; end
                            4'h2: begin rf_wd = vx_reg & rf_q;  kind_w = vmx_pkg::K_NONE; end
                            4'h3: begin rf_wd = vx_reg ^ rf_q;  kind_w = vmx_pkg::K_NONE; end
                            4'h4:
                            begin
                                sum9      = {1'b0, vx_reg} + {1'b0, rf_q};
                                rf_wd     = sum9[7:0];
                                flag_next = sum9[8];
                            end
                            4'h5:
                            begin
                                rf_wd     = vx_reg - rf_q;
                                flag_next = (vx_reg >= rf_q);
                            end
                            4'h6:
                            begin
                                rf_wd     = {1'b0, vx_reg[7:1]};
                                flag_next = vx_reg[0];
                            end
                            4'h7:
                            begin
                                rf_wd     = rf_q - vx_reg;
                                flag_next = (rf_q >= vx_reg);
                            end
                            4'hE:
                            begin
                                rf_wd     = {vx_reg[6:0], 1'b0};
                                flag_next = vx_reg[7];
                            end
                            default:
                            begin
                                rf_we  = 1'b0;
                                kind_w = vmx_pkg::K_NONE;
                                stop_next = 1'b1;  fault_next = vmx_pkg::ERR_BADOP;
                            end
                        endcase
                    end
                    4'hA: ip_next = {4'b0, op_addr};
                    4'hB:
                    begin
                        jt13 = {1'b0, op_addr} + {5'b0, vx_reg};
                        if (jt13[12])
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_RANGE;
                        end
                        else
                        begin
                            pc_next = jt13[11:0];
                        end
                    end
                    4'hC:
                    begin
                        rf_we = 1'b1;  rf_wd = rnd_reg & kk;
                    end
                    4'hD:
                    begin
                        if (ip17 + {13'b0, n} > vmx_pkg::MEM_LIMIT)
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_RANGE;
                        end
                        else
                        begin
                            kind_w     = (n == 4'd0) ? vmx_pkg::K_DRAW0 : vmx_pkg::K_DRAW;
                            cnt_next   = {1'b0, n};
                            erase_next = 1'b0;
                        end
                    end
                    4'hE:
                    begin
                        if (kk == vmx_pkg::KK_SKP)
                        begin
                            if (keys_reg[vx_reg[3:0]]) pc_next = at + 12'd4;
                        end
                        else if (kk == vmx_pkg::KK_SKNP)
                        begin
                            if (!keys_reg[vx_reg[3:0]]) pc_next = at + 12'd4;
                        end
                        else
                        begin
                            stop_next = 1'b1;  fault_next = vmx_pkg::ERR_BADOP;
                        end
                    end
                    default:
                    begin
                        case (kk)
                            vmx_pkg::KK_GDT:
                            begin
                                rf_we = 1'b1;  rf_wd = delay_reg;
                            end
                            vmx_pkg::KK_WKEY:
                            begin
                                if (pend_reg[4])
                                begin
                                    rf_we     = 1'b1;
                                    rf_wd     = {4'b0, pend_reg[3:0]};
                                    pend_next = 5'd0;
                                end
                                else
                                begin
                                    pc_next = at;
                                end
                            end
                            vmx_pkg::KK_SDT:  delay_next = vx_reg;
                            vmx_pkg::KK_SST:  sound_next = vx_reg;
                            vmx_pkg::KK_ADDI: ip_next = ip_reg + {8'b0, vx_reg};
                            vmx_pkg::KK_FONT: ip_next = {12'b0, vx_reg[3:0]} * 16'd5;
                            vmx_pkg::KK_BCD:
                            begin
                                if (ip17 + 17'd3 > vmx_pkg::MEM_LIMIT)
                                begin
                                    stop_next = 1'b1;  fault_next = vmx_pkg::ERR_RANGE;
                                end
                                else
                                begin
                                    kind_w   = vmx_pkg::K_BCD;
                                    cnt_next = 5'd3;
                                end
                            end
                            vmx_pkg::KK_STR, vmx_pkg::KK_LDR:
                            begin
                                if (ip17 + {13'b0, x} + 17'd1 > vmx_pkg::MEM_LIMIT)
                                begin
                                    stop_next = 1'b1;  fault_next = vmx_pkg::ERR_RANGE;
                                end
                                else
                                begin
                                    kind_w   = (kk == vmx_pkg::KK_STR) ? vmx_pkg::K_STORE
                                                                       : vmx_pkg::K_LOAD;
                                    cnt_next = {1'b0, x} + 5'd1;
                                end
                            end
                            default:
                            begin
                                stop_next = 1'b1;  fault_next = vmx_pkg::ERR_BADOP;
                            end
                        endcase
                    end
                endcase
                kind_next = kind_w;
            end
            vmx_pkg::DP_WRVF:
            begin
                rf_we = 1'b1;  rf_wa = 4'hF;  rf_wd = {7'b0, flag_reg};
            end
            vmx_pkg::DP_JHI: mem_ra = pc_reg;
            vmx_pkg::DP_JLO:
            begin
                jhi_next = mem_q;
                mem_ra   = pc_reg + 12'd1;
            end
            vmx_pkg::DP_JCMP:
            begin
                if ({jhi_reg, mem_q} == ir_reg)
                begin
                    stop_next = 1'b1;  fault_next = vmx_pkg::ERR_LOOP;
                end
            end
            vmx_pkg::DP_LRD:
            begin
                mem_ra = loop_a;
                rf_ra  = li[3:0];
            end
            vmx_pkg::DP_LWR:
            begin
                case (kind_reg)
                    vmx_pkg::K_DRAW:
                    begin
                        scr_we = 1'b1;
                        scr_wd = cur ^ pat;
                        if ((cur & pat) != 64'd0) erase_next = 1'b1;
                    end
                    vmx_pkg::K_BCD:
                    begin
                        mem_we = 1'b1;
                        mem_wa = loop_a;
                        case (li[1:0])
                            2'd0:    mem_wd = {6'b0, hund};
                            2'd1:    mem_wd = {1'b0, tens7};
                            default: mem_wd = {4'b0, ones4};
                        endcase
                    end
                    vmx_pkg::K_STORE:
                    begin
                        mem_we = 1'b1;  mem_wa = loop_a;  mem_wd = rf_q;
                    end
                    vmx_pkg::K_LOAD:
                    begin
                        rf_we = 1'b1;  rf_wa = li[3:0];  rf_wd = mem_q;
                    end
                    default: rf_we = 1'b0;
                endcase
            end
            vmx_pkg::DP_DEND:
            begin
                rf_we = 1'b1;  rf_wa = 4'hF;  rf_wd = {7'b0, erase_reg};
            end
            default: rf_we = 1'b0;
        endcase
        if (cfg_we)
        begin
            pc_next = cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem_array[mem_wa] <= mem_wd;
        mem_q <= mem_array[mem_ra];
        if (scr_we) scr_array[scr_wa] <= scr_wd;
        scr_q <= scr_vld_reg[scr_ra] ? scr_array[scr_ra] : 64'd0;
        if (rf_we) rf_array[rf_wa] <= rf_wd;
        rf_q <= rf_vld_reg[rf_ra] ? rf_array[rf_ra] : 8'd0;
        if (stk_we) stk_array[sp_reg[SW-1:0]] <= at + 12'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_vld_reg <= '0;
            rf_vld_reg  <= '0;
            pc_reg      <= vmx_pkg::PC_RESET;
            ip_reg      <= '0;
            sp_reg      <= '0;
            delay_reg   <= '0;
            sound_reg   <= '0;
            pend_reg    <= '0;
            stop_reg    <= 1'b0;
            fault_reg   <= '0;
            mode_reg    <= '0;
            kind_reg    <= vmx_pkg::K_NONE;
            cnt_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            if (scr_clr) scr_vld_reg <= '0;
            else if (scr_we) scr_vld_reg[scr_wa] <= 1'b1;
            if (rf_we) rf_vld_reg[rf_wa] <= 1'b1;
            pc_reg    <= pc_next;
            ip_reg    <= ip_next;
            sp_reg    <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            pend_reg  <= pend_next;
            stop_reg  <= stop_next;
            fault_reg <= fault_next;
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg    <= ir_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        jhi_reg   <= jhi_next;
        flag_reg  <= flag_next;
        erase_reg <= erase_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        rnd_reg   <= rnd_next;
        keys_reg  <= keys_next;
        keyc_reg  <= keyc_next;
        rowi_reg  <= rowi_next;
    end

endmodule

`default_nettype wire

/* rtl/core/vmx_checker.sv */
// Port-level checks of the core and the bind that attaches them to the top level.
// Depends on vm_instruction_execute_core_unit_defines.svh.
`default_nettype none
`include "vm_instruction_execute_core_unit_defines.svh"

module vmx_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       halted,
    input wire logic [2:0] error_code
);

    `VMX_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `VMX_ASSERT_NXT(a_halt_sticky, clk, rst_n, halted, halted)
    `VMX_ASSERT_IMP(a_fault_halt, clk, rst_n, 1'b1, halted == (error_code != 3'd0))
    `VMX_ASSERT_IMP(a_one_in_flight, clk, rst_n, !in_stall, !out_valid)

endmodule

bind vm_instruction_execute_core_unit vmx_checker u_vmx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .halted     (halted),
    .error_code (error_code)
);

`default_nettype wire
